FILE: hw/rtl/tha_pkg.sv
package tha_pkg;

    localparam int POOL_BYTES   = 512;
    localparam int TICKET_COUNT = 128;

    localparam int AW     = $clog2(POOL_BYTES);
    localparam int PTR_W  = $clog2(POOL_BYTES + 1);
    localparam int TKT_W  = $clog2(TICKET_COUNT);
    localparam int NEED_W = 11;
    localparam int SUM_W  = ((PTR_W > NEED_W) ? PTR_W : NEED_W) + 1;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [TKT_W-1:0] tkt_t;

    localparam logic [2:0] CMD_ALLOC   = 3'd0;
    localparam logic [2:0] CMD_FREE    = 3'd1;
    localparam logic [2:0] CMD_LOOKUP  = 3'd2;
    localparam logic [2:0] CMD_RESIZE  = 3'd3;
    localparam logic [2:0] CMD_COMPACT = 3'd4;
    localparam logic [2:0] CMD_WRITE   = 3'd5;
    localparam logic [2:0] CMD_READ    = 3'd6;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD      = 3'd1;
    localparam logic [2:0] ST_NO_TKT   = 3'd2;
    localparam logic [2:0] ST_NO_SPACE = 3'd3;
    localparam logic [2:0] ST_SAME     = 3'd4;

    typedef struct packed {
        logic [2:0] command;
        logic [6:0] ticket_id;
        logic [9:0] request_size;
        logic [8:0] byte_address;
        logic [6:0] write_data;
    } in_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [6:0]        result_ticket;
        logic [8:0]        data_address;
        logic signed [7:0] read_data;
        logic [9:0]        free_tail_bytes;
    } out_t;

    // marker byte: ticket negated, 8-bit two's complement
    function automatic logic [7:0] mark_of(input logic [6:0] t);
        return 8'h00 - {1'b0, t};
    endfunction

endpackage

FILE: hw/rtl/ticket_heap_allocator_with_compaction_unit.sv
// Every pool scan, compaction or copy moves one byte per cycle through the pool RAM port;
// every command ends with a tail measurement, a downward scan for the last marker byte.
// One transaction at a time; input is accepted while a result waits in the output register.
// Reset: synchronous active-low aresetn clears the ticket flags, then a clearing pass
// zeroes the pool before the first input transaction is taken.
module ticket_heap_allocator_with_compaction_unit
    import tha_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    typedef enum logic [22:0] {
        S_CLEAR    = 23'd1 << 0,
        S_IDLE     = 23'd1 << 1,
        S_DISPATCH = 23'd1 << 2,
        S_BYTE     = 23'd1 << 3,
        S_FINDB    = 23'd1 << 4,
        S_FINDE    = 23'd1 << 5,
        S_RSZ      = 23'd1 << 6,
        S_GROWCHK  = 23'd1 << 7,
        S_TKT      = 23'd1 << 8,
        S_FIT      = 23'd1 << 9,
        S_CMP      = 23'd1 << 10,
        S_CMPCPY   = 23'd1 << 11,
        S_CMPEND   = 23'd1 << 12,
        S_ZERO     = 23'd1 << 13,
        S_PLACE0   = 23'd1 << 14,
        S_MARK     = 23'd1 << 15,
        S_PLACED   = 23'd1 << 16,
        S_SHR1     = 23'd1 << 17,
        S_SHR2     = 23'd1 << 18,
        S_COPY     = 23'd1 << 19,
        S_FREEDONE = 23'd1 << 20,
        S_TAIL     = 23'd1 << 21,
        S_FIN      = 23'd1 << 22
    } state_t;

    // which part of a resize-by-move is running
    typedef enum logic [1:0] {
        PH_MAIN = 2'd0,
        PH_COPY = 2'd1,
        PH_FREE = 2'd2
    } phase_t;

    localparam ptr_t P_PTR  = ptr_t'(POOL_BYTES);
    localparam ptr_t P_LAST = ptr_t'(POOL_BYTES - 1);

    state_t state_reg, state_next;
    state_t zret_reg, zret_next;
    phase_t ph_reg, ph_next;
    in_t    in_reg, in_next;

    ptr_t cur_reg, cur_next;      // address whose byte sits in ram_rdata
    ptr_t w_reg, w_next;          // write pointer: zero fill, compaction, copy target
    ptr_t zend_reg, zend_next;
    ptr_t b_reg, b_next;
    ptr_t e_reg, e_next;
    ptr_t at_reg, at_next;
    ptr_t run_reg, run_next;
    ptr_t start_reg, start_next;
    ptr_t na_reg, na_next;
    ptr_t tail_reg, tail_next;
    sum_t gend_reg, gend_next;    // block end at the new size
    logic [NEED_W-1:0] need_reg, need_next;
    logic inside_reg, inside_next;
    logic retry_reg, retry_next;
    logic plc_reg, plc_next;
    tkt_t t_reg, t_next;
    tkt_t nt_reg, nt_next;
    logic [TICKET_COUNT-1:0] in_use_reg, in_use_next;

    logic [2:0] st_reg, st_next;
    logic [6:0] tk_reg, tk_next;
    ptr_t       addr_reg, addr_next;
    logic [7:0] rd_reg, rd_next;

    logic m_valid_reg, m_valid_next;
    out_t m_data_reg, m_data_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    logic [7:0] tmark;
    logic [7:0] nmark;
    logic       tid_ok;
    tkt_t       tid_idx;
    sum_t       old_len;
    sum_t       need_s;
    sum_t       run_inc;
    ptr_t       fit_start;

    tha_ram #(
        .WIDTH (8),
        .DEPTH (POOL_BYTES)
    ) u_pool (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cur_next[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign tmark   = mark_of(in_reg.ticket_id);
    assign nmark   = mark_of(7'(t_reg));
    assign tid_ok  = (in_reg.ticket_id != 7'd0) &&
                     ({1'b0, in_reg.ticket_id} < 8'(TICKET_COUNT));
    assign tid_idx = in_reg.ticket_id[TKT_W-1:0];
    assign old_len = sum_t'(e_reg) - sum_t'(b_reg) + sum_t'(1);
    assign need_s  = sum_t'(need_reg);
    assign run_inc = sum_t'(run_reg) + sum_t'(1);
    assign fit_start = (run_reg == '0) ? cur_reg : start_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        zret_next    = zret_reg;
        ph_next      = ph_reg;
        in_next      = in_reg;
        cur_next     = cur_reg;
        w_next       = w_reg;
        zend_next    = zend_reg;
        b_next       = b_reg;
        e_next       = e_reg;
        at_next      = at_reg;
        run_next     = run_reg;
        start_next   = start_reg;
        na_next      = na_reg;
        tail_next    = tail_reg;
        gend_next    = gend_reg;
        need_next    = need_reg;
        inside_next  = inside_reg;
        retry_next   = retry_reg;
        plc_next     = plc_reg;
        t_next       = t_reg;
        nt_next      = nt_reg;
        in_use_next  = in_use_reg;
        st_next      = st_reg;
        tk_next      = tk_reg;
        addr_next    = addr_reg;
        rd_next      = rd_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = w_reg[AW-1:0];
        ram_wdata    = 8'h00;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg[AW-1:0];
                if (cur_reg == P_LAST) begin
                    state_next = S_IDLE;
                end else begin
                    cur_next = cur_reg + ptr_t'(1);
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                st_next    = ST_BAD;
                tk_next    = 7'd0;
                addr_next  = '0;
                rd_next    = 8'h00;
                ph_next    = PH_MAIN;
                retry_next = 1'b0;
                plc_next   = 1'b0;
                need_next  = NEED_W'(in_reg.request_size) + NEED_W'(3);
                t_next     = tkt_t'(1);
                state_next = S_TAIL;
                cur_next   = P_LAST;
                case (in_reg.command)
                    CMD_ALLOC: begin
                        if (in_reg.request_size != 10'd0) begin
                            state_next = S_TKT;
                        end
                    end
                    CMD_FREE, CMD_LOOKUP: begin
                        if (tid_ok) begin
                            state_next = S_FINDB;
                            cur_next   = '0;
                        end
                    end
                    CMD_RESIZE: begin
                        if (tid_ok && (in_reg.request_size != 10'd0)) begin
                            if (sum_t'(in_reg.request_size) >= sum_t'(POOL_BYTES - 3)) begin
                                st_next = ST_NO_SPACE;
                            end else begin
                                state_next = S_FINDB;
                                cur_next   = '0;
                            end
                        end
                    end
                    CMD_COMPACT: begin
                        w_next     = '0;
                        cur_next   = '0;
                        state_next = S_CMP;
                    end
                    CMD_WRITE, CMD_READ: begin
                        if (sum_t'(in_reg.byte_address) < sum_t'(POOL_BYTES)) begin
                            cur_next   = ptr_t'(in_reg.byte_address);
                            state_next = S_BYTE;
                        end
                    end
                    default: ;
                endcase
            end
            S_BYTE: begin
                if (in_reg.command == CMD_READ) begin
                    rd_next = ram_rdata;
                    st_next = ST_OK;
                end else if (!ram_rdata[7]) begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_reg[AW-1:0];
                    ram_wdata = {1'b0, in_reg.write_data};
                    st_next   = ST_OK;
                end
                state_next = S_TAIL;
                cur_next   = P_LAST;
            end
            S_FINDB: begin
                if (cur_reg >= P_PTR) begin
                    if (ph_reg == PH_MAIN) begin
                        state_next = S_TAIL;
                        cur_next   = P_LAST;
                    end else if (ph_reg == PH_COPY) begin
                        ph_next  = PH_FREE;
                        cur_next = '0;
                    end else begin
                        st_next    = ST_OK;
                        tk_next    = 7'(nt_reg);
                        addr_next  = na_reg;
                        state_next = S_TAIL;
                        cur_next   = P_LAST;
                    end
                end else if (ram_rdata == tmark) begin
                    b_next = cur_reg;
                    if (in_reg.command == CMD_LOOKUP) begin
                        st_next    = ST_OK;
                        addr_next  = cur_reg + ptr_t'(1);
                        state_next = S_TAIL;
                        cur_next   = P_LAST;
                    end else if (ph_reg == PH_COPY) begin
                        w_next     = na_reg;
                        cur_next   = cur_reg + ptr_t'(1);
                        state_next = S_COPY;
                    end else begin
                        cur_next   = cur_reg + ptr_t'(1);
                        state_next = S_FINDE;
                    end
                end else begin
                    cur_next = cur_reg + ptr_t'(1);
                end
            end
            S_FINDE: begin
                if ((cur_reg >= P_PTR) || (ram_rdata == tmark)) begin
                    if ((in_reg.command == CMD_RESIZE) && (ph_reg == PH_MAIN)) begin
                        if (cur_reg >= P_PTR) begin
                            state_next = S_TAIL;
                            cur_next   = P_LAST;
                        end else begin
                            e_next     = cur_reg;
                            state_next = S_RSZ;
                        end
                    end else begin
                        // free: a lone marker is cleared by itself
                        w_next     = b_reg;
                        zend_next  = (cur_reg >= P_PTR) ? b_reg : cur_reg;
                        zret_next  = S_FREEDONE;
                        state_next = S_ZERO;
                    end
                end else begin
                    cur_next = cur_reg + ptr_t'(1);
                end
            end
            S_RSZ: begin
                gend_next = sum_t'(b_reg) + need_s - sum_t'(1);
                if (need_s == old_len) begin
                    st_next    = ST_SAME;
                    tk_next    = in_reg.ticket_id;
                    addr_next  = b_reg + ptr_t'(1);
                    state_next = S_TAIL;
                    cur_next   = P_LAST;
                end else if (need_s < old_len) begin
                    w_next     = ptr_t'(sum_t'(b_reg) + need_s);
                    zend_next  = e_reg;
                    zret_next  = S_SHR1;
                    state_next = S_ZERO;
                end else begin
                    cur_next   = e_reg + ptr_t'(1);
                    state_next = S_GROWCHK;
                end
            end
            S_GROWCHK: begin
                if ((cur_reg >= P_PTR) || (ram_rdata != 8'h00)) begin
                    state_next = S_TKT;
                end else if (sum_t'(cur_reg) == gend_reg) begin
                    w_next     = e_reg;
                    zend_next  = ptr_t'(gend_reg - sum_t'(1));
                    zret_next  = S_MARK;
                    plc_next   = 1'b0;
                    state_next = S_ZERO;
                end else begin
                    cur_next = cur_reg + ptr_t'(1);
                end
            end
            S_TKT: begin
                if (!in_use_reg[t_reg]) begin
                    cur_next    = '0;
                    run_next    = '0;
                    start_next  = '0;
                    inside_next = 1'b0;
                    state_next  = S_FIT;
                end else if (t_reg == tkt_t'(TICKET_COUNT - 1)) begin
                    st_next    = ST_NO_TKT;
                    state_next = S_TAIL;
                    cur_next   = P_LAST;
                end else begin
                    t_next = t_reg + tkt_t'(1);
                end
            end
            S_FIT: begin
                if (cur_reg >= P_PTR) begin
                    if (retry_reg) begin
                        st_next    = ST_NO_SPACE;
                        state_next = S_TAIL;
                        cur_next   = P_LAST;
                    end else begin
                        retry_next = 1'b1;
                        w_next     = '0;
                        cur_next   = '0;
                        state_next = S_CMP;
                    end
                end else begin
                    cur_next = cur_reg + ptr_t'(1);
                    if (ram_rdata[7]) begin
                        inside_next = !inside_reg;
                        run_next    = '0;
                    end else if (!inside_reg) begin
                        start_next = fit_start;
                        run_next   = ptr_t'(run_inc);
                        if (run_inc == need_s) begin
                            at_next    = fit_start;
                            state_next = S_PLACE0;
                        end
                    end
                end
            end
            S_CMP, S_CMPCPY: begin
                if (cur_reg >= P_PTR) begin
                    zend_next  = P_LAST;
                    zret_next  = S_CMPEND;
                    state_next = S_ZERO;
                end else if (ram_rdata[7] || (state_reg == S_CMPCPY)) begin
                    // copy marker or body byte down to the packed position
                    ram_we    = 1'b1;
                    ram_waddr = w_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                    w_next    = w_reg + ptr_t'(1);
                    cur_next  = cur_reg + ptr_t'(1);
                    if (state_reg == S_CMP) begin
                        state_next = S_CMPCPY;
                    end else if (ram_rdata[7]) begin
                        state_next = S_CMP;
                    end
                end else begin
                    cur_next = cur_reg + ptr_t'(1);
                end
            end
            S_CMPEND: begin
                if (in_reg.command == CMD_COMPACT) begin
                    st_next    = ST_OK;
                    state_next = S_TAIL;
                    cur_next   = P_LAST;
                end else begin
                    cur_next    = '0;
                    run_next    = '0;
                    start_next  = '0;
                    inside_next = 1'b0;
                    state_next  = S_FIT;
                end
            end
            S_ZERO: begin
                if (w_reg > zend_reg) begin
                    state_next = zret_reg;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = w_reg[AW-1:0];
                    w_next    = w_reg + ptr_t'(1);
                end
            end
            S_PLACE0: begin
                ram_we     = 1'b1;
                ram_waddr  = at_reg[AW-1:0];
                ram_wdata  = nmark;
                w_next     = at_reg + ptr_t'(1);
                zend_next  = ptr_t'(sum_t'(at_reg) + need_s - sum_t'(2));
                zret_next  = S_MARK;
                plc_next   = 1'b1;
                state_next = S_ZERO;
            end
            S_MARK: begin
                ram_we    = 1'b1;
                ram_waddr = w_reg[AW-1:0];
                ram_wdata = plc_reg ? nmark : tmark;
                if (plc_reg) begin
                    state_next = S_PLACED;
                end else begin
                    st_next    = ST_OK;
                    tk_next    = in_reg.ticket_id;
                    addr_next  = b_reg + ptr_t'(1);
                    state_next = S_TAIL;
                    cur_next   = P_LAST;
                end
            end
            S_PLACED: begin
                in_use_next[t_reg] = 1'b1;
                if (in_reg.command == CMD_ALLOC) begin
                    st_next    = ST_OK;
                    tk_next    = 7'(t_reg);
                    addr_next  = at_reg + ptr_t'(1);
                    state_next = S_TAIL;
                    cur_next   = P_LAST;
                end else begin
                    nt_next    = t_reg;
                    na_next    = at_reg + ptr_t'(1);
                    ph_next    = PH_COPY;
                    cur_next   = '0;
                    state_next = S_FINDB;
                end
            end
            S_SHR1: begin
                ram_we     = 1'b1;
                ram_waddr  = gend_reg[AW-1:0];
                ram_wdata  = tmark;
                state_next = S_SHR2;
            end
            S_SHR2: begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(gend_reg - sum_t'(1));
                st_next    = ST_OK;
                tk_next    = in_reg.ticket_id;
                addr_next  = b_reg + ptr_t'(1);
                state_next = S_TAIL;
                cur_next   = P_LAST;
            end
            S_COPY: begin
                if ((cur_reg >= P_PTR) || (w_reg >= P_PTR) ||
                    (ram_rdata == 8'h00) || ram_rdata[7]) begin
                    ph_next    = PH_FREE;
                    cur_next   = '0;
                    state_next = S_FINDB;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = w_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                    w_next    = w_reg + ptr_t'(1);
                    cur_next  = cur_reg + ptr_t'(1);
                end
            end
            S_FREEDONE: begin
                in_use_next[tid_idx] = 1'b0;
                st_next = ST_OK;
                if (ph_reg == PH_FREE) begin
                    tk_next   = 7'(nt_reg);
                    addr_next = na_reg;
                end
                state_next = S_TAIL;
                cur_next   = P_LAST;
            end
            S_TAIL: begin
                // downward scan for the last marker byte
                if (ram_rdata[7]) begin
                    tail_next  = P_LAST - cur_reg;
                    state_next = S_FIN;
                end else if (cur_reg == '0) begin
                    tail_next  = P_PTR;
                    state_next = S_FIN;
                end else begin
                    cur_next = cur_reg - ptr_t'(1);
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.status          = st_reg;
                    m_data_next.result_ticket   = tk_reg;
                    m_data_next.data_address    = 9'(addr_reg);
                    m_data_next.read_data       = rd_reg;
                    m_data_next.free_tail_bytes = 10'(tail_reg);
                    state_next                  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cur_reg     <= '0;
            in_use_reg  <= '0;
            m_valid_reg <= 1'b0;
            ph_reg      <= PH_MAIN;
            zret_reg    <= S_IDLE;
            retry_reg   <= 1'b0;
            plc_reg     <= 1'b0;
            inside_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            in_use_reg  <= in_use_next;
            m_valid_reg <= m_valid_next;
            ph_reg      <= ph_next;
            zret_reg    <= zret_next;
            retry_reg   <= retry_next;
            plc_reg     <= plc_next;
            inside_reg  <= inside_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        w_reg      <= w_next;
        zend_reg   <= zend_next;
        b_reg      <= b_next;
        e_reg      <= e_next;
        at_reg     <= at_next;
        run_reg    <= run_next;
        start_reg  <= start_next;
        na_reg     <= na_next;
        tail_reg   <= tail_next;
        gend_reg   <= gend_next;
        need_reg   <= need_next;
        t_reg      <= t_next;
        nt_reg     <= nt_next;
        st_reg     <= st_next;
        tk_reg     <= tk_next;
        addr_reg   <= addr_next;
        rd_reg     <= rd_next;
        m_data_reg <= m_data_next;
    end

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_DISPATCH)
        else $error("accepted transaction not dispatched");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !ram_we)
        else $error("pool written while idle");

    a_result_loads_once: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FIN && (!m_valid_reg || m_ready) |=> m_valid_reg && s_ready)
        else $error("result not presented");

    a_alloc_ok_ticket: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_PLACED |-> !in_use_reg[t_reg])
        else $error("ticket granted twice");

endmodule

FILE: hw/rtl/tha_ram.sv
module tha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write-first on a same-address collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
